### sv/tlsba_pkg.sv
// Shared types and constants for the two-level slot bitmap allocator.
`default_nettype none

package tlsba_pkg;

  // Default sizes for the top-level parameters
  localparam int PAGES_DEF     = 256;
  localparam int SLOTS_MAX_DEF = 64;

  // Fixed field widths
  localparam int PAGE_W   = 8;
  localparam int SLOT_W   = 7;
  localparam int RSLOT_W  = 6;
  localparam int CNT_W    = 7;
  localparam int PAGE_CAP = 256;

  // Pages 0 and 1 are reserved: always in use, always full
  localparam int RESERVED_PAGES = 2;

  // Page search splits the page bitmaps into groups of this width
  localparam int GRP_W  = 16;
  localparam int GRP_IW = 4;

  localparam logic [CNT_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NEXT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NONE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_READ,
    S_SCAN
  } state_t;

endpackage

`default_nettype wire

### sv/two_level_slot_bitmap_allocator_core.sv
// Top level of the two-level slot bitmap allocator: page bitmaps, slot-map memory, control.
`default_nettype none

// Record slot allocator. Page occupancy and page-full marks sit in flip-flop bitmaps; each
// page's slot map and slot count sit in one synchronous memory (one read port, one write
// port, registered read data). An operation is accepted when start is high and busy low;
// its single result is shown for exactly one cycle with out_strobe and cannot be held off.
// Steps after accept: delete and check read the addressed page as they are taken and strobe
// from the READ state; insert runs the two-step page search, opens or reads the chosen page
// from PICK and strobes from READ, or strobes from PICK when no page is available. Next
// walks the slot-map memory one page per cycle from the start page upward and strobes when
// it finds an occupied slot or has passed the last page.
// busy is low in the strobe cycle, so a new transaction can be taken right then.
// slots_per_page is written through cfg_wr_en/cfg_wr_data and is used clamped to
// 1..SLOTS_MAX; write it only while busy is low. No clearing pass is needed after reset.
module two_level_slot_bitmap_allocator_core #(
  parameter int PAGES     = tlsba_pkg::PAGES_DEF,
  parameter int SLOTS_MAX = tlsba_pkg::SLOTS_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_op,
  input  wire logic [tlsba_pkg::PAGE_W-1:0] in_page_index,
  input  wire logic signed [tlsba_pkg::SLOT_W-1:0] in_slot_index,
  input  wire logic                         cfg_wr_en,
  input  wire logic [tlsba_pkg::CNT_W-1:0]  cfg_wr_data,
  output logic                              out_strobe,
  output logic [1:0]                        out_status,
  output logic [tlsba_pkg::PAGE_W-1:0]      out_result_page,
  output logic [tlsba_pkg::RSLOT_W-1:0]     out_result_slot
);
  import tlsba_pkg::*;

  localparam int USABLE = (PAGES < PAGE_CAP) ? PAGES : PAGE_CAP;
  localparam int PW     = $clog2(USABLE);
  localparam int SW     = $clog2(SLOTS_MAX);
  localparam int NG     = (USABLE + GRP_W - 1) / GRP_W;
  localparam int GSW    = (NG > 1) ? $clog2(NG) : 1;
  localparam int MW     = SLOTS_MAX + CNT_W;
  localparam logic [PAGE_W:0]  USABLE_W = (PAGE_W+1)'(USABLE);
  localparam logic [PAGE_W:0]  RSV_W    = (PAGE_W+1)'(RESERVED_PAGES);
  localparam logic [CNT_W-1:0] SMAX_W   = CNT_W'(SLOTS_MAX);

  // Control and state registers
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cfg_r;
  logic [USABLE-1:0]      in_use_r, in_use_nxt;
  logic [USABLE-1:0]      full_r, full_nxt;
  op_t                    op_r, op_nxt;
  logic [PAGE_W-1:0]      page_r, page_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic                   page_ok_r, page_ok_nxt;
  logic [CNT_W-1:0]       from_r, from_nxt;
  logic [PAGE_W:0]        scan_r, scan_nxt;
  logic                   first_r, first_nxt;
  logic                   chk_v_r, chk_v_nxt;
  logic [PW-1:0]          cur_page_r, cur_page_nxt;
  logic [CNT_W-1:0]       cur_from_r, cur_from_nxt;
  logic                   cur_en_r, cur_en_nxt;
  logic                   fresh_r, fresh_nxt;
  logic                   strobe_r, strobe_nxt;
  status_t                status_r, status_nxt;
  logic [PAGE_W-1:0]      rpage_r, rpage_nxt;
  logic [RSLOT_W-1:0]     rslot_r, rslot_nxt;

  // Slot-map memory: {slot count, slot map} per page
  logic [MW-1:0]          mem [USABLE];
  logic [MW-1:0]          q_r;
  logic                   rd_en, wr_en;
  logic [PW-1:0]          rd_addr;
  logic [MW-1:0]          wr_data;

  // Page search group registers
  logic [NG-1:0]          ga_any_r, gf_any_r;
  logic [GRP_IW-1:0]      ga_idx_r [NG];
  logic [GRP_IW-1:0]      gf_idx_r [NG];
  logic [NG-1:0]          ga_any, gf_any;
  logic [GRP_IW-1:0]      ga_idx [NG];
  logic [GRP_IW-1:0]      gf_idx [NG];
  logic [NG*GRP_W-1:0]    avail_pad, free_pad;
  logic [GSW-1:0]         ga_sel, gf_sel;
  logic [PW-1:0]          tgt_a, tgt_f;
  logic                   any_a, any_f;

  // Datapath signals
  logic [CNT_W-1:0]       lim;
  logic [SLOTS_MAX-1:0]   lim_mask, from_mask, slot_sel, map_w, enc_vec, enc_bit;
  logic [CNT_W-1:0]       cnt_w, cnt_inc, cnt_dec;
  logic [SLOTS_MAX-1:0]   map_clr;
  logic                   enc_any;
  logic [SW-1:0]          enc_idx;
  logic                   pg_ok, sl_ok, slot_hit, scan_live, scan_hit;

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_result_page = rpage_r;
  assign out_result_slot = rslot_r;

  // Slot limit in force, clamped to 1..SLOTS_MAX
  always_comb begin
    priority if (cfg_r == '0) begin
      lim = CNT_W'(1);
    end else if (cfg_r > SMAX_W) begin
      lim = SMAX_W;
    end else begin
      lim = cfg_r;
    end
  end

  // Per-slot masks
  always_comb begin
    for (int i = 0; i < SLOTS_MAX; i++) begin
      lim_mask[i]  = (CNT_W'(i) < lim);
      from_mask[i] = (CNT_W'(i) >= cur_from_r);
      slot_sel[i]  = (slot_r == SLOT_W'(i));
    end
  end

  // Read data; a freshly opened page reads as empty
  assign map_w   = fresh_r ? '0 : q_r[SLOTS_MAX-1:0];
  assign cnt_w   = fresh_r ? '0 : q_r[MW-1:SLOTS_MAX];
  assign cnt_inc = cnt_w + CNT_W'(1);
  assign cnt_dec = cnt_w - CNT_W'(1);
  assign map_clr = map_w & ~slot_sel;

  // Lowest-slot encoder: clear slot for insert, occupied slot for next
  assign enc_vec = (op_r == OP_INSERT) ? (~map_w & lim_mask) : (map_w & lim_mask & from_mask);
  always_comb begin
    enc_idx = '0;
    for (int i = SLOTS_MAX - 1; i >= 0; i--) begin
      if (enc_vec[i]) enc_idx = SW'(i);
    end
  end
  assign enc_any = |enc_vec;
  always_comb begin
    for (int i = 0; i < SLOTS_MAX; i++) begin
      enc_bit[i] = enc_any && (enc_idx == SW'(i));
    end
  end

  // Delete/check validity
  assign slot_hit = page_ok_r && |(map_w & slot_sel);
  assign pg_ok    = ({1'b0, in_page_index} < USABLE_W) && ({1'b0, in_page_index} >= RSV_W)
                    && in_use_r[in_page_index[PW-1:0]];
  assign sl_ok    = !in_slot_index[SLOT_W-1] && (CNT_W'(unsigned'(in_slot_index)) < lim);

  // Scan progress
  assign scan_live = (scan_r < USABLE_W);
  assign scan_hit  = chk_v_r && cur_en_r && enc_any;

  // Page search, first level: lowest candidate within each group
  always_comb begin
    avail_pad = '0;
    free_pad  = '0;
    avail_pad[USABLE-1:0] = in_use_r & ~full_r;
    free_pad[USABLE-1:0]  = ~in_use_r;
    for (int g = 0; g < NG; g++) begin
      ga_any[g] = |avail_pad[g*GRP_W +: GRP_W];
      gf_any[g] = |free_pad[g*GRP_W +: GRP_W];
      ga_idx[g] = '0;
      gf_idx[g] = '0;
      for (int j = GRP_W - 1; j >= 0; j--) begin
        if (avail_pad[g*GRP_W + j]) ga_idx[g] = GRP_IW'(j);
        if (free_pad[g*GRP_W + j])  gf_idx[g] = GRP_IW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    ga_any_r <= ga_any;
    gf_any_r <= gf_any;
    for (int g = 0; g < NG; g++) begin
      ga_idx_r[g] <= ga_idx[g];
      gf_idx_r[g] <= gf_idx[g];
    end
  end

  // Page search, second level: lowest group
  always_comb begin
    ga_sel = '0;
    gf_sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (ga_any_r[g]) ga_sel = GSW'(g);
      if (gf_any_r[g]) gf_sel = GSW'(g);
    end
  end
  assign any_a = |ga_any_r;
  assign any_f = |gf_any_r;
  assign tgt_a = PW'({ga_sel, ga_idx_r[ga_sel]});
  assign tgt_f = PW'({gf_sel, gf_idx_r[gf_sel]});

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (op_t'(in_op))
            OP_INSERT: state_nxt = S_PICK;
            OP_NEXT:   state_nxt = S_SCAN;
            OP_DELETE,
            OP_CHECK:  state_nxt = S_READ;
          endcase
        end
      end
      S_PICK: state_nxt = (any_a || any_f) ? S_READ : S_IDLE;
      S_READ: state_nxt = S_IDLE;
      S_SCAN: begin
        if (scan_hit || (!scan_live && !chk_v_r)) state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, memory access and results
  always_comb begin
    in_use_nxt   = in_use_r;
    full_nxt     = full_r;
    op_nxt       = op_r;
    page_nxt     = page_r;
    slot_nxt     = slot_r;
    page_ok_nxt  = page_ok_r;
    from_nxt     = from_r;
    scan_nxt     = scan_r;
    first_nxt    = first_r;
    chk_v_nxt    = 1'b0;
    cur_page_nxt = cur_page_r;
    cur_from_nxt = cur_from_r;
    cur_en_nxt   = cur_en_r;
    fresh_nxt    = fresh_r;
    rd_en        = 1'b0;
    rd_addr      = cur_page_r;
    wr_en        = 1'b0;
    wr_data      = '0;
    strobe_nxt   = 1'b0;
    status_nxt   = ST_OK;
    rpage_nxt    = '0;
    rslot_nxt    = '0;
    unique case (state_r)
      // Accept: capture the transaction and read the addressed page
      S_IDLE: begin
        if (start) begin
          op_nxt       = op_t'(in_op);
          page_nxt     = in_page_index;
          slot_nxt     = in_slot_index;
          page_ok_nxt  = pg_ok && sl_ok;
          from_nxt     = in_slot_index[SLOT_W-1] ? '0 : (in_slot_index + SLOT_W'(1));
          scan_nxt     = {1'b0, in_page_index};
          first_nxt    = 1'b1;
          cur_page_nxt = in_page_index[PW-1:0];
          cur_from_nxt = '0;
          cur_en_nxt   = 1'b1;
          fresh_nxt    = 1'b0;
          rd_en        = 1'b1;
          rd_addr      = in_page_index[PW-1:0];
        end
      end
      // Insert: pick a partly filled page, else open a free one
      S_PICK: begin
        priority if (any_a) begin
          cur_page_nxt = tgt_a;
          fresh_nxt    = 1'b0;
          rd_en        = 1'b1;
          rd_addr      = tgt_a;
        end else if (any_f) begin
          cur_page_nxt = tgt_f;
          fresh_nxt    = 1'b1;
        end else begin
          strobe_nxt = 1'b1;
          status_nxt = ST_NONE;
        end
      end
      // Read-modify-write of the slot map
      S_READ: begin
        strobe_nxt = 1'b1;
        unique case (op_r)
          OP_INSERT: begin
            in_use_nxt[cur_page_r] = 1'b1;
            if (enc_any) begin
              wr_en     = 1'b1;
              wr_data   = {cnt_inc, map_w | enc_bit};
              full_nxt[cur_page_r] = (cnt_inc >= lim);
              rpage_nxt = PAGE_W'(cur_page_r);
              rslot_nxt = RSLOT_W'(enc_idx);
            end else begin
              full_nxt[cur_page_r] = 1'b1;
              status_nxt = ST_NONE;
            end
          end
          OP_DELETE: begin
            if (slot_hit) begin
              wr_en = 1'b1;
              full_nxt[cur_page_r] = 1'b0;
              if ((cnt_dec == '0) || (map_clr == '0)) begin
                in_use_nxt[cur_page_r] = 1'b0;
                wr_data = '0;
              end else begin
                wr_data = {cnt_dec, map_clr};
              end
              rpage_nxt = page_r;
              rslot_nxt = slot_r[RSLOT_W-1:0];
            end else begin
              status_nxt = ST_INVALID;
            end
          end
          OP_CHECK: begin
            if (slot_hit) begin
              rpage_nxt = page_r;
              rslot_nxt = slot_r[RSLOT_W-1:0];
            end else begin
              status_nxt = ST_INVALID;
            end
          end
          OP_NEXT: begin
            status_nxt = ST_NONE;
          end
        endcase
      end
      // Next: read one page per cycle, test the page read last cycle
      S_SCAN: begin
        if (scan_live) begin
          rd_en        = 1'b1;
          rd_addr      = scan_r[PW-1:0];
          cur_page_nxt = scan_r[PW-1:0];
          cur_from_nxt = first_r ? from_r : '0;
          cur_en_nxt   = (scan_r >= RSV_W) && in_use_r[scan_r[PW-1:0]];
          first_nxt    = 1'b0;
          scan_nxt     = scan_r + (PAGE_W+1)'(1);
          chk_v_nxt    = 1'b1;
        end
        if (scan_hit) begin
          strobe_nxt = 1'b1;
          rpage_nxt  = PAGE_W'(cur_page_r);
          rslot_nxt  = RSLOT_W'(enc_idx);
        end else if (!scan_live && !chk_v_r) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_NONE;
        end
      end
    endcase
  end

  // Slot-map memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_page_r] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cfg_r    <= CFG_RESET;
      in_use_r <= {{(USABLE-RESERVED_PAGES){1'b0}}, {RESERVED_PAGES{1'b1}}};
      full_r   <= {{(USABLE-RESERVED_PAGES){1'b0}}, {RESERVED_PAGES{1'b1}}};
      chk_v_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      in_use_r <= in_use_nxt;
      full_r   <= full_nxt;
      chk_v_r  <= chk_v_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Transaction and result payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    page_r     <= page_nxt;
    slot_r     <= slot_nxt;
    page_ok_r  <= page_ok_nxt;
    from_r     <= from_nxt;
    scan_r     <= scan_nxt;
    first_r    <= first_nxt;
    cur_page_r <= cur_page_nxt;
    cur_from_r <= cur_from_nxt;
    cur_en_r   <= cur_en_nxt;
    fresh_r    <= fresh_nxt;
    status_r   <= status_nxt;
    rpage_r    <= rpage_nxt;
    rslot_r    <= rslot_nxt;
  end

endmodule

`default_nettype wire
